>>> src/tclp_pkg.sv
// ----------------------------------------------------------------------------
// tclp_pkg: shared types and constants
// Character codes, level limits and the store request that passes from the
// command parser to the level store.
// ----------------------------------------------------------------------------
`default_nettype none

package tclp_pkg;

  // Item kinds carried on the input tuser
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Characters the parser reacts to
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_ONE     = 8'h31;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  localparam int unsigned LED_COUNT_DEF = 4;
  localparam int unsigned LED_NUM_W     = 4;  // holds LED numbers up to 9
  localparam int unsigned LEVEL_W       = 7;
  localparam int unsigned FLAG_W        = 4;  // LEDs shown on the output

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;
  localparam logic [LEVEL_W-1:0] PWM_LAST   = 7'd99;
  localparam logic [1:0]         MAX_DIGITS = 2'd3;

  typedef struct packed {
    logic                 we;
    logic [LED_NUM_W-1:0] led;
    logic [LEVEL_W-1:0]   level;
  } store_req_t;

endpackage : tclp_pkg

`default_nettype wire

>>> src/text_command_led_pwm_unit.sv
// ----------------------------------------------------------------------------
// text_command_led_pwm_unit: text-command LED dimmer with PWM output
// Bytes drive a command parser that sets per-LED brightness (0..100); ticks
// step a 0..99 counter and refresh the LED on flags.
// ----------------------------------------------------------------------------
// Flow: an accepted request sits in the input register; parser/compare fill
//   the result register when the work stage takes it (not while stalled).
// Throughput: one request per cycle while results drain (a held result stalls
//   the input); the per-request state update in parser and level store sets it.
// Reset: rst_ni asynchronous, active low; parser idle, all levels 0, PWM step
//   counter 0, all LEDs off, both pipeline registers empty.
`default_nettype none

module text_command_led_pwm_unit #(
  parameter int unsigned LED_COUNT = tclp_pkg::LED_COUNT_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input stream
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  wire logic       s_axis_tuser,   // [0] op (0 byte, 1 tick)
  // result stream
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [3:0] led_lit, [7:4] zero
  output logic            m_axis_tuser    // [0] level_written
);
  import tclp_pkg::*;

  // Input register: holds one request until the work stage takes it.
  logic       in_valid_q;
  logic       in_op_q;
  logic [7:0] in_byte_q;

  // Result register: one finished result waiting for the sink.
  logic              out_valid_q;
  logic [FLAG_W-1:0] out_led_q;
  logic              out_wr_q;

  logic              adv;       // work stage consumes the held request
  logic              byte_en, tick_en;
  store_req_t        store_req;
  logic [FLAG_W-1:0] lit_next;
  logic              written;

  // The work stage moves whenever the result register is free or draining,
  // so the input side keeps flowing while a result drains.
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign byte_en       = adv && (in_op_q == OP_BYTE);
  assign tick_en       = adv && (in_op_q == OP_TICK);

  tclp_parser #(
    .LED_COUNT (LED_COUNT)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (byte_en),
    .byte_i    (in_byte_q),
    .req_o     (store_req)
  );

  tclp_levels #(
    .LED_COUNT (LED_COUNT)
  ) u_levels (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick_en),
    .req_i      (store_req),
    .lit_next_o (lit_next),
    .written_o  (written)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
    if (adv) begin
      out_led_q <= lit_next;
      out_wr_q  <= written;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_led_q};
  assign m_axis_tuser  = out_wr_q;

  // A store request only comes from a byte the work stage is consuming.
  a_store_on_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req.we |-> byte_en)
    else $error("store request without a consumed byte");

  // Parser never asks to store a level above full scale.
  a_store_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req.we |-> (store_req.level <= LEVEL_FULL))
    else $error("store request level out of range");

  // A held request that the work stage cannot take stays put.
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> (in_valid_q && $stable(in_byte_q) && $stable(in_op_q)))
    else $error("input register changed while stalled");

  // A tick never reports a written level.
  a_tick_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_en |=> (out_valid_q && !out_wr_q))
    else $error("tick result flagged as level write");

endmodule : text_command_led_pwm_unit

`default_nettype wire

>>> src/tclp_parser.sv
// ----------------------------------------------------------------------------
// tclp_parser: text command parser
// Four-phase parser for "<led> <value>" commands; issues a store request on
// the byte that completes a valid value, and on a leading zero at once.
// ----------------------------------------------------------------------------
`default_nettype none

module tclp_parser #(
  parameter int unsigned LED_COUNT = tclp_pkg::LED_COUNT_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                byte_en_i,
  input  wire logic [7:0]          byte_i,
  output tclp_pkg::store_req_t     req_o
);
  import tclp_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT_LED   = 2'd0,
    PH_WAIT_SPACE = 2'd1,
    PH_WAIT_VALUE = 2'd2,
    PH_READ_VALUE = 2'd3
  } phase_e;

  localparam logic [7:0] LED_LAST_CHAR = CHAR_ZERO + 8'(LED_COUNT);

  phase_e               phase_q, phase_d;
  logic [LED_NUM_W-1:0] tgt_q, tgt_d;
  logic [LEVEL_W-1:0]   acc_q, acc_d;
  logic [1:0]           cnt_q, cnt_d;

  logic       is_digit, is_led_digit, is_eol;
  logic [3:0] digit;
  logic [9:0] acc_next;

  assign is_digit     = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign is_led_digit = (byte_i >= CHAR_ONE) && (byte_i <= LED_LAST_CHAR);
  assign is_eol       = (byte_i == CHAR_CR) || (byte_i == CHAR_LF);
  assign digit        = byte_i[3:0];
  // acc*10 + digit, kept wide so values past 100 are caught untruncated
  assign acc_next     = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {6'd0, digit};

  always_comb begin
    phase_d = phase_q;
    tgt_d   = tgt_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    req_o   = '0;
    req_o.led = tgt_q;
    if (byte_en_i) begin
      if (is_eol) begin
        // single digit value: 0 is off, 1 is full
        if (phase_q == PH_READ_VALUE && cnt_q == 2'd1) begin
          if (acc_q == '0) begin
            req_o.we    = 1'b1;
            req_o.level = '0;
          end else if (acc_q == 7'd1) begin
            req_o.we    = 1'b1;
            req_o.level = LEVEL_FULL;
          end
        end
        phase_d = PH_WAIT_LED;
        tgt_d   = '0;
        acc_d   = '0;
        cnt_d   = '0;
      end else begin
        case (phase_q)
          PH_WAIT_LED: begin
            if (is_led_digit) begin
              tgt_d   = digit;
              phase_d = PH_WAIT_SPACE;
            end
          end
          PH_WAIT_SPACE: begin
            if (byte_i == CHAR_SPACE) begin
              phase_d = PH_WAIT_VALUE;
            end else if (is_led_digit) begin
              tgt_d = digit;
            end else begin
              phase_d = PH_WAIT_LED;
              tgt_d   = '0;
              acc_d   = '0;
              cnt_d   = '0;
            end
          end
          PH_WAIT_VALUE: begin
            if (byte_i == CHAR_SPACE) begin
              phase_d = PH_WAIT_VALUE;
            end else if (is_digit) begin
              acc_d   = {3'b000, digit};
              cnt_d   = 2'd1;
              phase_d = PH_READ_VALUE;
              // leading zero turns the LED off right away
              if (digit == 4'd0) begin
                req_o.we    = 1'b1;
                req_o.level = '0;
              end
            end else begin
              phase_d = PH_WAIT_LED;
              tgt_d   = '0;
              acc_d   = '0;
              cnt_d   = '0;
            end
          end
          PH_READ_VALUE: begin
            if (is_digit && cnt_q < MAX_DIGITS && acc_next <= 10'(LEVEL_FULL)) begin
              acc_d = acc_next[LEVEL_W-1:0];
              cnt_d = cnt_q + 2'd1;
            end else begin
              if (byte_i == CHAR_PERCENT) begin
                req_o.we    = 1'b1;
                req_o.level = acc_q;
              end
              phase_d = PH_WAIT_LED;
              tgt_d   = '0;
              acc_d   = '0;
              cnt_d   = '0;
            end
          end
          default: begin
            phase_d = PH_WAIT_LED;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT_LED;
      tgt_q   <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      tgt_q   <= tgt_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule : tclp_parser

`default_nettype wire

>>> src/tclp_levels.sv
// ----------------------------------------------------------------------------
// tclp_levels: brightness store and PWM compare
// Holds one level per LED, the step counter and the lit flags of the last
// tick. Gives the flags and write strobe that the current item produces.
// ----------------------------------------------------------------------------
`default_nettype none

module tclp_levels #(
  parameter int unsigned LED_COUNT = tclp_pkg::LED_COUNT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          tick_i,
  input  wire tclp_pkg::store_req_t          req_i,
  output logic [tclp_pkg::FLAG_W-1:0]        lit_next_o,
  output logic                               written_o
);
  import tclp_pkg::*;

  localparam int unsigned SHOWN = (LED_COUNT < FLAG_W) ? LED_COUNT : FLAG_W;

  logic [LEVEL_W-1:0] level_q [LED_COUNT];
  logic [LEVEL_W-1:0] level_d [LED_COUNT];
  logic [LEVEL_W-1:0] pwm_q, pwm_d;
  logic [FLAG_W-1:0]  lit_q, lit_d, lit_calc;
  logic               led_ok;

  assign led_ok    = (req_i.led >= LED_NUM_W'(1)) && (req_i.led <= LED_NUM_W'(LED_COUNT));
  assign written_o = req_i.we && led_ok && (req_i.level <= LEVEL_FULL);

  always_comb begin
    lit_calc = '0;
    for (int k = 0; k < SHOWN; k++) begin
      lit_calc[k] = level_q[k] > pwm_q;
    end
  end

  always_comb begin
    for (int k = 0; k < LED_COUNT; k++) begin
      level_d[k] = level_q[k];
      if (written_o && req_i.led == LED_NUM_W'(k + 1)) begin
        level_d[k] = req_i.level;
      end
    end
    lit_d = tick_i ? lit_calc : lit_q;
    pwm_d = pwm_q;
    if (tick_i) begin
      pwm_d = (pwm_q == PWM_LAST) ? '0 : pwm_q + 7'd1;
    end
  end

  assign lit_next_o = lit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LED_COUNT; k++) begin
        level_q[k] <= '0;
      end
      pwm_q <= '0;
      lit_q <= '0;
    end else begin
      level_q <= level_d;
      pwm_q   <= pwm_d;
      lit_q   <= lit_d;
    end
  end

endmodule : tclp_levels

`default_nettype wire

>>> dv/tb_text_command_led_pwm_unit.sv
// ----------------------------------------------------------------------------
// tb_text_command_led_pwm_unit: stream testbench for the LED dimmer
// Feeds command bytes and PWM ticks, predicts the LED flags and the store
// flag per request, and checks every result in order under random idling.
// ----------------------------------------------------------------------------

module tb_text_command_led_pwm_unit;

  import tclp_pkg::*;

  localparam int unsigned LEDS      = LED_COUNT_DEF;
  localparam int unsigned MAX_PRINT = 40;

  typedef enum logic [1:0] {
    AWAIT_LED,
    AWAIT_SPACE,
    AWAIT_VALUE,
    IN_VALUE
  } cmd_phase_e;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [FLAG_W-1:0] led_lit;
    logic              level_written;
  } led_result_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tuser  = OP_BYTE;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;

  text_command_led_pwm_unit #(
    .LED_COUNT(LEDS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Dimmer prediction: parser, level store and PWM step counter
  // --------------------------------------------------------------------------
  cmd_phase_e         cmd_phase  = AWAIT_LED;
  logic [LED_NUM_W-1:0] cmd_led  = '0;
  int unsigned        cmd_value  = 0;
  int unsigned        cmd_digits = 0;
  logic [LEVEL_W-1:0] led_level [LEDS];
  logic [LEVEL_W-1:0] pwm_step   = '0;
  logic [FLAG_W-1:0]  lit_now    = '0;

  initial begin
    for (int k = 0; k < LEDS; k++) led_level[k] = '0;
  end

  function automatic void clear_command();
    cmd_phase  = AWAIT_LED;
    cmd_led    = '0;
    cmd_value  = 0;
    cmd_digits = 0;
  endfunction

  function automatic logic store_level(input int unsigned led, input int unsigned lvl);
    if (led >= 1 && led <= LEDS && lvl <= LEVEL_FULL) begin
      led_level[led-1] = LEVEL_W'(lvl);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic led_result_t predict_dimmer(input logic op, input logic [7:0] b);
    led_result_t res;
    logic        is_digit;
    logic        is_led;
    int unsigned v;
    res.level_written = 1'b0;
    is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    is_led   = (b >= CHAR_ONE) && (b <= CHAR_ZERO + 8'(LEDS));
    if (op == OP_TICK) begin
      // flags reflect the step before it advances
      lit_now = '0;
      for (int k = 0; k < LEDS && k < FLAG_W; k++)
        if (led_level[k] > pwm_step) lit_now[k] = 1'b1;
      pwm_step = (pwm_step == PWM_LAST) ? '0 : pwm_step + 1'b1;
    end else if (b == CHAR_CR || b == CHAR_LF) begin
      // single digit ended by a line break: 0 is off, 1 is full
      if (cmd_phase == IN_VALUE && cmd_digits == 1) begin
        if (cmd_value == 0) res.level_written = store_level(cmd_led, 0);
        else if (cmd_value == 1) res.level_written = store_level(cmd_led, LEVEL_FULL);
      end
      clear_command();
    end else begin
      case (cmd_phase)
        AWAIT_LED: begin
          if (is_led) begin
            cmd_led   = LED_NUM_W'(b - CHAR_ZERO);
            cmd_phase = AWAIT_SPACE;
          end
        end
        AWAIT_SPACE: begin
          if (b == CHAR_SPACE) cmd_phase = AWAIT_VALUE;
          else if (is_led) cmd_led = LED_NUM_W'(b - CHAR_ZERO);
          else clear_command();
        end
        AWAIT_VALUE: begin
          if (b == CHAR_SPACE) begin
            // extra spaces are skipped
          end else if (is_digit) begin
            cmd_value  = b - CHAR_ZERO;
            cmd_digits = 1;
            cmd_phase  = IN_VALUE;
            // leading zero switches the LED off right away
            if (cmd_value == 0) res.level_written = store_level(cmd_led, 0);
          end else begin
            clear_command();
          end
        end
        default: begin
          if (is_digit) begin
            v = cmd_value * 10 + (b - CHAR_ZERO);
            if (cmd_digits >= MAX_DIGITS || v > LEVEL_FULL) begin
              clear_command();
            end else begin
              cmd_value  = v;
              cmd_digits = cmd_digits + 1;
            end
          end else if (b == CHAR_PERCENT) begin
            res.level_written = store_level(cmd_led, cmd_value);
            clear_command();
          end else begin
            clear_command();
          end
        end
      endcase
    end
    res.led_lit = lit_now;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  rx_item_t    byte_tick_q[$];
  led_result_t expected_q[$];

  function automatic void push_byte(input logic [7:0] b);
    rx_item_t it;
    it.op      = OP_BYTE;
    it.rx_byte = b;
    byte_tick_q.push_back(it);
  endfunction

  function automatic void push_tick();
    rx_item_t it;
    it.op      = OP_TICK;
    it.rx_byte = 8'($urandom_range(0, 255));  // ignored by the block
    byte_tick_q.push_back(it);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  // Mostly well-formed commands with random content, some of them broken
  function automatic void push_command();
    int unsigned val;
    string       digits;
    if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
    else push_byte(CHAR_ZERO + 8'($urandom_range(1, LEDS)));
    if ($urandom_range(0, 9) == 0) push_byte(CHAR_ZERO + 8'($urandom_range(1, LEDS)));
    if ($urandom_range(0, 11) != 0)
      repeat ($urandom_range(1, 3)) push_byte(CHAR_SPACE);
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 3) == 0) push_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
      else push_byte(CHAR_ZERO + 8'($urandom_range(0, 1)));
      push_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
    end else begin
      val = ($urandom_range(0, 4) == 0) ? $urandom_range(101, 999) : $urandom_range(0, 100);
      case ($urandom_range(0, 7))
        0:       digits = $sformatf("%03d", val);
        1:       digits = $sformatf("%04d", val);
        default: digits = $sformatf("%0d", val);
      endcase
      push_text(digits);
      if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(0, 255)));
      else push_byte(CHAR_PERCENT);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Idling and mismatch reporting
  // --------------------------------------------------------------------------
  int unsigned fail_count = 0;

  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    if (calm || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic flag_mismatch(input string msg);
    if (fail_count < MAX_PRINT) $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  rx_item_t    next_item;
  led_result_t predicted;
  int unsigned send_gap  = 0;
  bit          send_calm = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = predict_dimmer(s_axis_tuser, s_axis_tdata);
        expected_q.push_back(predicted);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_tick_q.size() != 0) begin
          next_item = byte_tick_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_item.rx_byte;
          s_axis_tuser  <= next_item.op;
          send_gap = draw_wait(send_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and receiver stalls
  // --------------------------------------------------------------------------
  led_result_t want;
  int unsigned recv_hold = 0;
  bit          recv_calm = 1'b0;
  logic        long_hold = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing pending: tdata=%h tuser=%b",
                                  m_axis_tdata, m_axis_tuser));
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata !== {{(8-FLAG_W){1'b0}}, want.led_lit})
            flag_mismatch($sformatf("led_lit got %h want %h", m_axis_tdata, want.led_lit));
          if (m_axis_tuser !== want.level_written)
            flag_mismatch($sformatf("level_written got %b want %b",
                                    m_axis_tuser, want.level_written));
        end
        recv_hold = draw_wait(recv_calm);
      end else if (recv_hold > 0) begin
        recv_hold--;
      end
      m_axis_tready <= (recv_hold == 0) && !long_hold;
    end
  end

  // Long receiver hold-offs so the block backs up and stalls its input
  initial begin
    wait (rst_ni);
    repeat (300) @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (150) @(posedge clk_i);
    long_hold <= 1'b0;
    repeat (1200) @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (150) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence: directed commands, then random traffic, then drain
  // --------------------------------------------------------------------------
  initial begin
    push_text("4 100%");     // full level through percent form
    push_tick();
    push_text("12  0");      // LED digit replaced, extra space, leading zero
    push_byte(CHAR_CR);
    push_text("3 1");        // single 1 means full
    push_byte(CHAR_LF);
    push_text("2 260%");     // above 100: parser resets, '%' is then ignored
    push_tick();
    push_byte(8'hFF);
    push_byte(8'h00);

    while (byte_tick_q.size() < 1100) begin
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      else
        push_command();
      repeat ($urandom_range(0, 8)) push_tick();
    end

    wait (rst_ni);
    @(posedge clk_i);
    while (byte_tick_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
